// ===== rtl/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg: shared types and constants of the Fresnel reflectance pipeline
// Field widths, fixed-point constants and the stage payload structs.
// ----------------------------------------------------------------------------
package fdr_pkg;

  localparam int IDX_W  = 15;  // refractive index, Q2.13
  localparam int ANG_W  = 31;  // angle quantities, 30 fraction bits, up to 1.0
  localparam int RAD_W  = 62;  // square-root radicand
  localparam int NUM_W  = 46;  // index times angle quantity
  localparam int RNUM_W = 63;  // ratio numerator, 17 fraction bits shifted in
  localparam int RDEN_W = 47;  // ratio denominator
  localparam int RQ_W   = 18;  // ratio quotient, up to 1.0 in Q1.17
  localparam int SQ_W   = 36;  // squared ratio
  localparam int REFL_W = 16;

  localparam logic [ANG_W-1:0]  ANG_ONE  = 31'h4000_0000;
  localparam logic [RQ_W-1:0]   R_ONE    = 18'h2_0000;
  localparam logic [REFL_W-1:0] REFL_ONE = 16'h8000;

  typedef struct packed {
    logic [IDX_W-1:0] n_t;
    logic [IDX_W-1:0] n_i;
  } idx_t;

  typedef struct packed {
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    idx_t               idx;
  } s1_t;

  typedef struct packed {
    logic [ANG_W-1:0] cos_i;
    idx_t             idx;
  } base_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    base_t            b;
  } s3_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    base_t            b;
  } s4_t;

  typedef struct packed {
    logic  tir;
    base_t b;
  } dtag_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    dtag_t            t;
  } s5_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    dtag_t            t;
  } s6_t;

  typedef struct packed {
    logic [NUM_W-1:0] a1;
    logic [NUM_W-1:0] b1;
    logic [NUM_W-1:0] a2;
    logic [NUM_W-1:0] b2;
    logic             tir;
  } s7_t;

  typedef struct packed {
    logic       tir;
    logic [1:0] zero;
  } rtag_t;

  typedef struct packed {
    logic [1:0][RNUM_W-1:0] num;
    logic [1:0][RDEN_W-1:0] den;
    rtag_t                  t;
  } s8_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq1;
    logic [SQ_W-1:0] sq2;
    logic            tir;
  } s9_t;

  typedef struct packed {
    logic [REFL_W-1:0] refl;
    logic              tir;
  } s10_t;

endpackage

// ===== rtl/fdr_slice.sv =====
// ----------------------------------------------------------------------------
// fdr_slice: one pipeline register stage with valid and backpressure
// Takes a beat when empty or when the downstream side takes its own beat.
// ----------------------------------------------------------------------------
module fdr_slice #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  // advance when empty or when the beat leaves
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // capture payload only on an accepted beat
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== rtl/fdr_sqrt.sv =====
// ----------------------------------------------------------------------------
// fdr_sqrt: pipelined floor integer square root
// One root bit per stage, RW/2 stages; a sideband tag travels with each beat.
// ----------------------------------------------------------------------------
module fdr_sqrt #(
  parameter int RW = 62,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [RW-1:0]   in_rad,
  input  logic [TW-1:0]   in_tag,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [RW/2-1:0] out_root,
  output logic [TW-1:0]   out_tag
);

  localparam int N    = RW / 2;
  localparam int REMW = N + 2;

  logic            v_r      [N];
  logic [REMW-1:0] rem_r    [N];
  logic [N-1:0]    root_r   [N];
  logic [RW-1:0]   rad_r    [N];
  logic [TW-1:0]   tag_r    [N];
  logic [REMW-1:0] rem_nxt  [N];
  logic [N-1:0]    root_nxt [N];
  logic [RW-1:0]   rad_nxt  [N];
  logic [TW-1:0]   tag_nxt  [N];
  logic            vsrc     [N];
  logic [N:0]      rdy;

  // ready chain: a stage moves when empty or when the next one moves
  always_comb begin
    rdy[N] = out_ready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // one digit step per stage
  always_comb begin
    logic [REMW-1:0] rem_src;
    logic [REMW-1:0] rem_x;
    logic [REMW-1:0] trial;
    logic [N-1:0]    root_src;
    logic [RW-1:0]   rad_src;
    logic            ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rem_src    = '0;
        root_src   = '0;
        rad_src    = in_rad;
        vsrc[k]    = in_valid;
        tag_nxt[k] = in_tag;
      end else begin
        rem_src    = rem_r[k-1];
        root_src   = root_r[k-1];
        rad_src    = rad_r[k-1];
        vsrc[k]    = v_r[k-1];
        tag_nxt[k] = tag_r[k-1];
      end
      rem_x       = {rem_src[REMW-3:0], rad_src[RW-1:RW-2]};
      trial       = {root_src, 2'b01};
      ge          = rem_x >= trial;
      rem_nxt[k]  = ge ? rem_x - trial : rem_x;
      root_nxt[k] = {root_src[N-2:0], ge};
      rad_nxt[k]  = rad_src << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (rdy[k]) v_r[k] <= vsrc[k];
      end
    end
  end

  // hold payload unless a beat enters the stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (rdy[k] && vsrc[k]) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        tag_r[k]  <= tag_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_tag   = tag_r[N-1];

endmodule

// ===== rtl/fdr_div.sv =====
// ----------------------------------------------------------------------------
// fdr_div: pipelined restoring divider, one quotient bit per stage
// Needs num < den * 2**QW; lanes share one handshake and one sideband tag.
// ----------------------------------------------------------------------------
module fdr_div #(
  parameter int LANES = 1,
  parameter int NW    = 46,
  parameter int DW    = 15,
  parameter int QW    = 31,
  parameter int TW    = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [LANES-1:0][NW-1:0]  in_num,
  input  logic [LANES-1:0][DW-1:0]  in_den,
  input  logic [TW-1:0]             in_tag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [LANES-1:0][QW-1:0]  out_quo,
  output logic [TW-1:0]             out_tag
);

  logic                     v_r     [QW];
  logic [LANES-1:0][DW-1:0] rem_r   [QW];
  logic [LANES-1:0][QW-1:0] low_r   [QW];
  logic [LANES-1:0][DW-1:0] den_r   [QW];
  logic [TW-1:0]            tag_r   [QW];
  logic [LANES-1:0][DW-1:0] rem_nxt [QW];
  logic [LANES-1:0][QW-1:0] low_nxt [QW];
  logic [LANES-1:0][DW-1:0] den_nxt [QW];
  logic [TW-1:0]            tag_nxt [QW];
  logic                     vsrc    [QW];
  logic [QW:0]              rdy;

  // ready chain across the stages
  always_comb begin
    rdy[QW] = out_ready;
    for (int k = QW - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // shift one numerator bit in, subtract when it fits
  always_comb begin
    logic [DW-1:0] rem_src;
    logic [QW-1:0] low_src;
    logic [DW:0]   t;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        vsrc[k]    = in_valid;
        tag_nxt[k] = in_tag;
      end else begin
        vsrc[k]    = v_r[k-1];
        tag_nxt[k] = tag_r[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          rem_src       = DW'(in_num[l][NW-1:QW]);
          low_src       = in_num[l][QW-1:0];
          den_nxt[k][l] = in_den[l];
        end else begin
          rem_src       = rem_r[k-1][l];
          low_src       = low_r[k-1][l];
          den_nxt[k][l] = den_r[k-1][l];
        end
        t  = {rem_src, low_src[QW-1]};
        ge = t >= {1'b0, den_nxt[k][l]};
        rem_nxt[k][l] = ge ? DW'(t - {1'b0, den_nxt[k][l]}) : t[DW-1:0];
        low_nxt[k][l] = {low_src[QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) v_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < QW; k++) begin
        if (rdy[k]) v_r[k] <= vsrc[k];
      end
    end
  end

  // hold payload unless a beat enters the stage
  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rdy[k] && vsrc[k]) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        den_r[k] <= den_nxt[k];
        tag_r[k] <= tag_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QW-1];
  assign out_quo   = low_r[QW-1];
  assign out_tag   = tag_r[QW-1];

endmodule

// ===== rtl/fresnel_dielectric_reflectance.sv =====
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance: unpolarized Fresnel reflectance pipeline
// Dot product, two square-root pipelines, Snell division and ratio division.
// ----------------------------------------------------------------------------
// The pipe holds ten register slices, two 31-stage square roots, a 31-stage and an
// 18-stage divider. Throughput: one beat per cycle while the output is not
// stalled; every stage fills its own bubble, so input is stalled only when
// the whole pipeline is full.
// Reset: synchronous active-low rst_n clears all valid bits; no data reset.
module fresnel_dielectric_reflectance #(
  parameter int VECTOR_FRAC_BITS = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic signed [15:0] in_incoming_x,
  input  logic signed [15:0] in_incoming_y,
  input  logic signed [15:0] in_incoming_z,
  input  logic [14:0]        in_surface_index,
  input  logic [14:0]        in_surrounding_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_reflectance,
  output logic               out_total_internal_reflection
);

  import fdr_pkg::*;

  localparam int SHL = (2 * VECTOR_FRAC_BITS < 30) ? 30 - 2 * VECTOR_FRAC_BITS : 0;
  localparam int SHR = (2 * VECTOR_FRAC_BITS > 30) ? 2 * VECTOR_FRAC_BITS - 30 : 0;
  localparam int MW  = 33 + SHL;

  logic [14:0] lv;
  logic [14:0] lr;

  s1_t   s1_c, s1_q;
  base_t s2_c, s2_q;
  s3_t   s3_c, s3_q;
  base_t q1_tag;
  logic [ANG_W-1:0] sin_i;
  s4_t   s4_c, s4_q;
  s5_t   s5_c, s5_q;
  logic [0:0][ANG_W-1:0] d1_quo;
  dtag_t d1_tag;
  s6_t   s6_c, s6_q;
  dtag_t q2_tag;
  logic [ANG_W-1:0] cos_t;
  s7_t   s7_c, s7_q;
  s8_t   s8_c, s8_q;
  logic [1:0][RQ_W-1:0] d2_quo;
  rtag_t d2_tag;
  s9_t   s9_c, s9_q;
  s10_t  s10_c, s10_q;

  assign lv[0]    = in_valid;
  assign in_stall = !lr[0];
  assign lr[14]   = !out_stall;

  // form the three component products
  always_comb begin
    s1_c.p0      = in_normal_x * in_incoming_x;
    s1_c.p1      = in_normal_y * in_incoming_y;
    s1_c.p2      = in_normal_z * in_incoming_z;
    s1_c.idx.n_t = in_surface_index;
    s1_c.idx.n_i = in_surrounding_index;
  end

  fdr_slice #(.W($bits(s1_t))) u_s1 (
    .clk, .rst_n, .in_valid(lv[0]), .in_ready(lr[0]), .in_data(s1_c),
    .out_valid(lv[1]), .out_ready(lr[1]), .out_data(s1_q)
  );

  // sum, take magnitude, align to 30 fraction bits and clamp to one
  always_comb begin
    logic signed [33:0] dot;
    logic [32:0]        mag;
    logic [MW-1:0]      al;
    dot = 34'(s1_q.p0) + 34'(s1_q.p1) + 34'(s1_q.p2);
    mag = 33'(dot[33] ? -dot : dot);
    al  = (MW'(mag) << SHL) >> SHR;
    s2_c.cos_i = (al > MW'(ANG_ONE)) ? ANG_ONE : al[ANG_W-1:0];
    s2_c.idx   = s1_q.idx;
  end

  fdr_slice #(.W($bits(base_t))) u_s2 (
    .clk, .rst_n, .in_valid(lv[1]), .in_ready(lr[1]), .in_data(s2_c),
    .out_valid(lv[2]), .out_ready(lr[2]), .out_data(s2_q)
  );

  // radicand of the incidence sine
  always_comb begin
    logic [61:0] prod;
    logic [31:0] diff;
    prod     = s2_q.cos_i * s2_q.cos_i;
    diff     = 32'(ANG_ONE) - prod[61:30];
    s3_c.rad = {diff, 30'b0};
    s3_c.b   = s2_q;
  end

  fdr_slice #(.W($bits(s3_t))) u_s3 (
    .clk, .rst_n, .in_valid(lv[2]), .in_ready(lr[2]), .in_data(s3_c),
    .out_valid(lv[3]), .out_ready(lr[3]), .out_data(s3_q)
  );

  fdr_sqrt #(.RW(RAD_W), .TW($bits(base_t))) u_sqrt_i (
    .clk, .rst_n, .in_valid(lv[3]), .in_ready(lr[3]), .in_rad(s3_q.rad),
    .in_tag(s3_q.b), .out_valid(lv[4]), .out_ready(lr[4]), .out_root(sin_i),
    .out_tag(q1_tag)
  );

  // Snell numerator
  always_comb begin
    s4_c.num = q1_tag.idx.n_i * sin_i;
    s4_c.b   = q1_tag;
  end

  fdr_slice #(.W($bits(s4_t))) u_s4 (
    .clk, .rst_n, .in_valid(lv[4]), .in_ready(lr[4]), .in_data(s4_c),
    .out_valid(lv[5]), .out_ready(lr[5]), .out_data(s4_q)
  );

  // total internal reflection when the quotient would exceed one
  always_comb begin
    logic [NUM_W-1:0] thr;
    thr        = {1'b0, s4_q.b.idx.n_t, 30'b0} + NUM_W'(s4_q.b.idx.n_t);
    s5_c.num   = s4_q.num;
    s5_c.t.b   = s4_q.b;
    s5_c.t.tir = (s4_q.b.idx.n_t == '0) ? (s4_q.num != '0) : (s4_q.num >= thr);
  end

  fdr_slice #(.W($bits(s5_t))) u_s5 (
    .clk, .rst_n, .in_valid(lv[5]), .in_ready(lr[5]), .in_data(s5_c),
    .out_valid(lv[6]), .out_ready(lr[6]), .out_data(s5_q)
  );

  fdr_div #(
    .LANES(1), .NW(NUM_W), .DW(IDX_W), .QW(ANG_W), .TW($bits(dtag_t))
  ) u_div_snell (
    .clk, .rst_n, .in_valid(lv[6]), .in_ready(lr[6]), .in_num(s5_q.num),
    .in_den(s5_q.t.b.idx.n_t), .in_tag(s5_q.t), .out_valid(lv[7]),
    .out_ready(lr[7]), .out_quo(d1_quo), .out_tag(d1_tag)
  );

  // radicand of the transmitted cosine; zero index leaves a zero sine
  always_comb begin
    logic [ANG_W-1:0] sin_t;
    logic [61:0]      prod;
    logic [31:0]      diff;
    sin_t    = (d1_tag.b.idx.n_t == '0) ? '0 : d1_quo[0];
    prod     = sin_t * sin_t;
    diff     = 32'(ANG_ONE) - prod[61:30];
    s6_c.rad = {diff, 30'b0};
    s6_c.t   = d1_tag;
  end

  fdr_slice #(.W($bits(s6_t))) u_s6 (
    .clk, .rst_n, .in_valid(lv[7]), .in_ready(lr[7]), .in_data(s6_c),
    .out_valid(lv[8]), .out_ready(lr[8]), .out_data(s6_q)
  );

  fdr_sqrt #(.RW(RAD_W), .TW($bits(dtag_t))) u_sqrt_t (
    .clk, .rst_n, .in_valid(lv[8]), .in_ready(lr[8]), .in_rad(s6_q.rad),
    .in_tag(s6_q.t), .out_valid(lv[9]), .out_ready(lr[9]), .out_root(cos_t),
    .out_tag(q2_tag)
  );

  // index-weighted cosines for both polarizations
  always_comb begin
    s7_c.a1  = q2_tag.b.idx.n_t * q2_tag.b.cos_i;
    s7_c.b1  = q2_tag.b.idx.n_i * cos_t;
    s7_c.a2  = q2_tag.b.idx.n_t * cos_t;
    s7_c.b2  = q2_tag.b.idx.n_i * q2_tag.b.cos_i;
    s7_c.tir = q2_tag.tir;
  end

  fdr_slice #(.W($bits(s7_t))) u_s7 (
    .clk, .rst_n, .in_valid(lv[9]), .in_ready(lr[9]), .in_data(s7_c),
    .out_valid(lv[10]), .out_ready(lr[10]), .out_data(s7_q)
  );

  // ratio numerators and denominators
  always_comb begin
    logic [NUM_W-1:0] d1;
    logic [NUM_W-1:0] d2;
    d1 = (s7_q.a1 > s7_q.b1) ? s7_q.a1 - s7_q.b1 : s7_q.b1 - s7_q.a1;
    d2 = (s7_q.a2 > s7_q.b2) ? s7_q.a2 - s7_q.b2 : s7_q.b2 - s7_q.a2;
    s8_c.num[0]  = {d1, 17'b0};
    s8_c.num[1]  = {d2, 17'b0};
    s8_c.den[0]  = RDEN_W'(s7_q.a1) + RDEN_W'(s7_q.b1);
    s8_c.den[1]  = RDEN_W'(s7_q.a2) + RDEN_W'(s7_q.b2);
    s8_c.t.zero  = {s8_c.den[1] == '0, s8_c.den[0] == '0};
    s8_c.t.tir   = s7_q.tir;
  end

  fdr_slice #(.W($bits(s8_t))) u_s8 (
    .clk, .rst_n, .in_valid(lv[10]), .in_ready(lr[10]), .in_data(s8_c),
    .out_valid(lv[11]), .out_ready(lr[11]), .out_data(s8_q)
  );

  fdr_div #(
    .LANES(2), .NW(RNUM_W), .DW(RDEN_W), .QW(RQ_W), .TW($bits(rtag_t))
  ) u_div_ratio (
    .clk, .rst_n, .in_valid(lv[11]), .in_ready(lr[11]), .in_num(s8_q.num),
    .in_den(s8_q.den), .in_tag(s8_q.t), .out_valid(lv[12]),
    .out_ready(lr[12]), .out_quo(d2_quo), .out_tag(d2_tag)
  );

  // saturate empty ratios to one and square them
  always_comb begin
    logic [RQ_W-1:0] r1;
    logic [RQ_W-1:0] r2;
    r1       = d2_tag.zero[0] ? R_ONE : d2_quo[0];
    r2       = d2_tag.zero[1] ? R_ONE : d2_quo[1];
    s9_c.sq1 = r1 * r1;
    s9_c.sq2 = r2 * r2;
    s9_c.tir = d2_tag.tir;
  end

  fdr_slice #(.W($bits(s9_t))) u_s9 (
    .clk, .rst_n, .in_valid(lv[12]), .in_ready(lr[12]), .in_data(s9_c),
    .out_valid(lv[13]), .out_ready(lr[13]), .out_data(s9_q)
  );

  // half sum truncated to Q1.15, forced to one on total reflection
  always_comb begin
    logic [SQ_W:0] sum;
    sum        = (SQ_W + 1)'(s9_q.sq1) + (SQ_W + 1)'(s9_q.sq2);
    s10_c.refl = s9_q.tir ? REFL_ONE : sum[35:20];
    s10_c.tir  = s9_q.tir;
  end

  fdr_slice #(.W($bits(s10_t))) u_s10 (
    .clk, .rst_n, .in_valid(lv[13]), .in_ready(lr[13]), .in_data(s10_c),
    .out_valid(lv[14]), .out_ready(lr[14]), .out_data(s10_q)
  );

  assign out_valid                     = lv[14];
  assign out_reflectance               = s10_q.refl;
  assign out_total_internal_reflection = s10_q.tir;

  // total reflection always reports full reflectance
  a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal_reflection |-> out_reflectance == REFL_ONE)
    else $error("reflection flag without full reflectance");

  // reflectance never exceeds one
  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= REFL_ONE)
    else $error("reflectance above one");

  // a free output lets every stage move, so input cannot stall
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

// ===== tb/fresnel_dielectric_reflectance_tb.sv =====
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_tb: self-checking bench for the reflectance pipe
// Drives directed and random hits in bursts, stalls the result side on its
// own pattern and checks every result beat against a fixed-point predictor.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_tb;

  localparam int VEC_FRAC   = 14;
  localparam int ANG_FRAC   = 30;
  localparam int RATIO_FRAC = 17;
  localparam int NUM_RANDOM = 850;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 200;

  typedef struct {
    logic signed [15:0] nx, ny, nz, ix, iy, iz;
    logic [14:0]        n_t, n_i;
  } hit_t;

  typedef struct {
    logic [15:0] refl;
    logic        tir;
  } shade_t;

  // Floor integer square root, bit by bit.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root, bit_w;
    root  = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= root + bit_w) begin
        v    = v - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // sqrt(1 - x^2) with 30 fraction bits.
  function automatic logic [63:0] cofactor(input logic [63:0] x);
    logic [63:0] one, sq;
    one = 64'd1 << ANG_FRAC;
    if (x > one) x = one;
    sq = (x * x) >> ANG_FRAC;
    return floor_sqrt((one - sq) << ANG_FRAC);
  endfunction

  // ((a-b)/(a+b))^2, saturating to 1.0 on a zero denominator.
  function automatic logic [63:0] polar_sq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] num, den, r;
    num = (a > b) ? a - b : b - a;
    den = a + b;
    r   = (den == 0) ? (64'd1 << RATIO_FRAC) : (num << RATIO_FRAC) / den;
    return r * r;
  endfunction

  function automatic shade_t fresnel_of(input hit_t h);
    shade_t      s;
    logic signed [63:0] dot;
    logic [63:0] mag, cos_i, sin_i, sin_t, cos_t, num, sum, one, nt, ni;
    logic        tir;
    one = 64'd1 << ANG_FRAC;
    nt  = 64'(h.n_t);
    ni  = 64'(h.n_i);
    dot = 64'(h.nx) * 64'(h.ix) + 64'(h.ny) * 64'(h.iy) + 64'(h.nz) * 64'(h.iz);
    mag = dot < 0 ? -dot : dot;
    mag = mag << (ANG_FRAC - 2 * VEC_FRAC);
    cos_i = mag > one ? one : mag;
    sin_i = cofactor(cos_i);
    num   = ni * sin_i;
    if (nt == 0) begin
      tir   = num != 0;
      sin_t = 0;
    end else begin
      sin_t = num / nt;
      tir   = sin_t > one;
    end
    if (tir) begin
      s.refl = 16'h8000;
      s.tir  = 1'b1;
      return s;
    end
    cos_t = cofactor(sin_t);
    sum = polar_sq(nt * cos_i, ni * cos_t) + polar_sq(nt * cos_t, ni * cos_i);
    s.refl = 16'(sum >> (2 * RATIO_FRAC - 15 + 1));
    s.tir  = 1'b0;
    return s;
  endfunction

  class fresnel_scoreboard;
    shade_t pending[$];
    int     errors;
    int     checked;
    int     tir_seen;

    function void note_hit(hit_t h);
      pending.push_back(fresnel_of(h));
    endfunction

    function void check_shade(logic [15:0] refl, logic tir);
      shade_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending: refl %0d tir %0d", refl, tir);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (tir) tir_seen++;
      if (refl !== e.refl) begin
        $error("reflectance: expected %0d actual %0d", e.refl, refl);
        errors++;
      end
      if (tir !== e.tir) begin
        $error("total_internal_reflection: expected %0d actual %0d", e.tir, tir);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic signed [15:0] in_incoming_x = '0, in_incoming_y = '0, in_incoming_z = '0;
  logic [14:0] in_surface_index = '0, in_surrounding_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_reflectance;
  logic out_total_internal_reflection;

  fresnel_scoreboard sb = new();
  hit_t hits[$];
  bit   hold_off = 1'b0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  fresnel_dielectric_reflectance #(.VECTOR_FRAC_BITS(VEC_FRAC)) i_dut (.*);

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [14:0] rand_index();
    case ($urandom_range(0, 7))
      0: return 15'd8192;
      1: return 15'd32767;
      2: return 15'($urandom);
      3: return 15'd0;
      default: return 15'($urandom_range(8192, 16384));
    endcase
  endfunction

  function automatic hit_t mk(int nx, int ny, int nz, int ix, int iy, int iz, int nt, int ni);
    hit_t h;
    h.nx = 16'(nx); h.ny = 16'(ny); h.nz = 16'(nz);
    h.ix = 16'(ix); h.iy = 16'(iy); h.iz = 16'(iz);
    h.n_t = 15'(nt); h.n_i = 15'(ni);
    return h;
  endfunction

  // Mostly a roughly unit pair: normal on z, incoming in the x-z plane; one hit in five takes random components.
  function automatic hit_t rand_hit();
    hit_t h;
    real  ang;
    if ($urandom_range(0, 9) < 2) begin
      h = mk(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
             rand_index(), rand_index());
    end else begin
      ang = $urandom_range(0, 15707) / 10000.0;
      h = mk(0, 0, 16384, $rtoi(16384.0 * $sin(ang)), 0, $rtoi(-16384.0 * $cos(ang)),
             rand_index(), rand_index());
      if ($urandom_range(0, 1)) h.iz = -h.iz;
    end
    return h;
  endfunction

  // Offer one beat and hold it until accepted.
  task automatic send_hit(input hit_t h);
    in_valid             <= 1'b1;
    in_normal_x          <= h.nx;
    in_normal_y          <= h.ny;
    in_normal_z          <= h.nz;
    in_incoming_x        <= h.ix;
    in_incoming_y        <= h.iy;
    in_incoming_z        <= h.iz;
    in_surface_index     <= h.n_t;
    in_surrounding_index <= h.n_i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_hit(h);
  endtask

  // Note accepted results, with sampling at the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_shade(out_reflectance, out_total_internal_reflection);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("fresnel_dielectric_reflectance_tb NOT OK");
      $finish;
    end
  end

  // Stall the result side on its own pattern, with one long hold-off.
  initial begin
    int mode;
    @(posedge rst_n);
    repeat (200) @(posedge clk);
    hold_off = 1'b1;
    out_stall <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
        @(posedge clk);
      end
    end
  end

  initial begin
    int gap;
    hit_t h;
    // Directed: head-on, grazing, flipped, overlong vectors, TIR, zero indices.
    hits.push_back(mk(0, 0, 16384, 0, 0, -16384, 12288, 8192));
    hits.push_back(mk(0, 0, 16384, 0, 0, 16384, 12288, 8192));
    hits.push_back(mk(0, 0, 16384, 16384, 0, 0, 12288, 8192));
    hits.push_back(mk(16384, 16384, 16384, 16384, 16384, 16384, 12288, 8192));
    hits.push_back(mk(-16384, -16384, -16384, 16384, 16384, 16384, 32767, 32767));
    hits.push_back(mk(0, 0, 16384, 11585, 0, -11585, 8192, 12288));
    hits.push_back(mk(0, 0, 16384, 11585, 0, -11585, 0, 12288));
    hits.push_back(mk(0, 0, 16384, 0, 0, -16384, 0, 12288));
    hits.push_back(mk(0, 0, 16384, 16384, 0, 0, 0, 0));
    hits.push_back(mk(0, 0, 16384, 0, 0, 16384, 0, 0));
    hits.push_back(mk(0, 0, 16384, 16384, 0, 0, 8192, 8192));
    hits.push_back(mk(0, 0, 16384, 11585, 0, -11585, 11585, 16384));
    hits.push_back(mk(0, 0, 0, 0, 0, 0, 32767, 8192));
    hits.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 0));
    hits.push_back(mk(32767, -1, 21845, -32768, 32767, -21846, 21845, 10922));
    hits.push_back(mk(0, 16384, 0, 0, -8192, 0, 32767, 32767));
    for (int i = 0; i < NUM_RANDOM; i++) hits.push_back(rand_hit());

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Send in bursts; keep offering during the long hold-off.
    while (hits.size() != 0) begin
      repeat ($urandom_range(1, 40)) begin
        if (hits.size() == 0) break;
        h = hits.pop_front();
        send_hit(h);
      end
      gap = hold_off ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("checked %0d reflectance results, %0d with total internal reflection",
             sb.checked, sb.tir_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("fresnel_dielectric_reflectance_tb OK");
    end else begin
      $display("fresnel_dielectric_reflectance_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fdr_pkg.sv
rtl/fdr_slice.sv
rtl/fdr_sqrt.sv
rtl/fdr_div.sv
rtl/fresnel_dielectric_reflectance.sv
tb/fresnel_dielectric_reflectance_tb.sv
